### design/vaf_pkg.sv
// Package: shared constants and the arctangent table for the vector angle block.
`timescale 1ns / 1ps

package vaf_pkg;

   localparam int GUARD_BITS = 24;
   localparam int PHASE_BITS = 32;
   localparam int ANGLE_BITS = 16;
   localparam int CSR_BITS   = 16;
   localparam int TABLE_LEN  = 24;
   localparam int TAB_IDX_BITS = 5;

   localparam logic [PHASE_BITS-1:0] ROUND_HALF = 32'h0000_8000;

   // Entry i is atan(2^-i) scaled so that 2^32 is one full turn, rounded to nearest.
   function automatic logic [PHASE_BITS-1:0] atan_entry(input logic [TAB_IDX_BITS-1:0] idx);
      logic [PHASE_BITS-1:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### design/vaf_req_if.sv
// Interface: input channel carrying one vector per item.
`timescale 1ns / 1ps

interface vaf_req_if #(
   parameter int COORD_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_BITS-1:0]  x_coord;
   logic signed [COORD_BITS-1:0]  y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

### design/vaf_rsp_if.sv
// Interface: result channel carrying one angle per item.
`timescale 1ns / 1ps

interface vaf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [vaf_pkg::ANGLE_BITS-1:0]   angle;
   logic                             zero_vector;

   modport source (output valid, output angle, output zero_vector, input ready);
   modport sink   (input valid, input angle, input zero_vector, output ready);
endinterface

### design/vector_angle_full_circle.sv
// Top level: pipelined CORDIC vectoring that turns a vector into a full-circle binary angle.
`timescale 1ns / 1ps

// The block accepts one (x, y) item per clock while the pipeline is not stalled, and returns
// its angle counter-clockwise from the positive x axis as a 16-bit binary angle (65536 is a
// full turn), rounded to nearest. Throughput is one item per cycle when the output is not
// stalled; each accepted item passes through an input register, a stage for the
// squares and the half-turn pre-rotation, a stage for the radius test, one CORDIC
// micro-rotation per stage, and an output register for rounding. Every stage has its own
// valid bit and moves when the stage after it is empty or moving, so bubbles close up behind
// a stalled output. Vectors with x*x + y*y below min_radius^2 give angle 0 and zero_vector
// set. A write to min_radius is seen by every item that has not yet reached the radius test,
// so it should be made while the block holds no items.

module vector_angle_full_circle #(
   parameter int ITERATIONS = 16,
   parameter int COORD_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   vaf_req_if.sink                         req_ch,
   vaf_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [vaf_pkg::CSR_BITS-1:0]    csr_wdata
);

   localparam int GB      = vaf_pkg::GUARD_BITS;
   localparam int PB      = vaf_pkg::PHASE_BITS;
   localparam int EXT     = 2;
   localparam int W       = COORD_BITS + 1 + GB + EXT;
   localparam int SQ_W    = 2 * COORD_BITS;
   localparam int RSQ_W   = 2 * vaf_pkg::CSR_BITS;
   localparam int CMP_W   = (SQ_W + 1 > RSQ_W) ? SQ_W + 1 : RSQ_W;
   localparam int NST     = ITERATIONS + 4;
   localparam int OUT_IDX = NST - 1;

   // Squared minimum radius, kept squared so the radius test is one add and compare.
   logic [RSQ_W-1:0] radius_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff <= RSQ_W'(1);
      end else if (csr_we) begin
         radius_sq_ff <= RSQ_W'(csr_wdata) * RSQ_W'(csr_wdata);
      end
   end

   logic [NST-1:0] valid_ff;
   logic [NST:0]   ready_w;

   assign ready_w[NST] = rsp_ch.ready;

   for (genvar k = 0; k < NST; k++) begin : g_ready
      assign ready_w[k] = !valid_ff[k] || ready_w[k+1];
   end

   assign req_ch.ready = ready_w[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (ready_w[0]) begin
            valid_ff[0] <= req_ch.valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (ready_w[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Input register.
   logic signed [COORD_BITS-1:0] xa_ff;
   logic signed [COORD_BITS-1:0] ya_ff;

   // Squares and the vector turned into the right half plane.
   logic signed [COORD_BITS:0]   xe_w;
   logic signed [COORD_BITS:0]   ye_w;
   logic signed [COORD_BITS:0]   xr_w;
   logic signed [COORD_BITS:0]   yr_w;
   logic signed [SQ_W-1:0]       sqx_w;
   logic signed [SQ_W-1:0]       sqy_w;
   logic [SQ_W-1:0]              sqx_ff;
   logic [SQ_W-1:0]              sqy_ff;
   logic signed [W-1:0]          xb_in;
   logic signed [W-1:0]          yb_in;
   logic signed [W-1:0]          xb_ff;
   logic signed [W-1:0]          yb_ff;
   logic                         half_ff;

   assign xe_w  = {xa_ff[COORD_BITS-1], xa_ff};
   assign ye_w  = {ya_ff[COORD_BITS-1], ya_ff};
   assign xr_w  = xa_ff[COORD_BITS-1] ? -xe_w : xe_w;
   assign yr_w  = xa_ff[COORD_BITS-1] ? -ye_w : ye_w;
   assign sqx_w = SQ_W'(xa_ff) * SQ_W'(xa_ff);
   assign sqy_w = SQ_W'(ya_ff) * SQ_W'(ya_ff);
   assign xb_in = {{EXT{xr_w[COORD_BITS]}}, xr_w, {GB{1'b0}}};
   assign yb_in = {{EXT{yr_w[COORD_BITS]}}, yr_w, {GB{1'b0}}};

   // CORDIC stages: entry 0 holds the pre-rotated vector, entry j+1 the result of step j.
   logic signed [W-1:0]  cx_ff [0:ITERATIONS];
   logic signed [W-1:0]  cy_ff [0:ITERATIONS];
   logic [PB-1:0]        cz_ff [0:ITERATIONS];
   logic                 short_ff [0:ITERATIONS];
   logic signed [W-1:0]  cx_in [1:ITERATIONS];
   logic signed [W-1:0]  cy_in [1:ITERATIONS];
   logic [PB-1:0]        cz_in [1:ITERATIONS];
   logic                 short_in;

   assign short_in = (CMP_W'(sqx_ff) + CMP_W'(sqy_ff)) < CMP_W'(radius_sq_ff);

   for (genvar j = 0; j < ITERATIONS; j++) begin : g_step
      logic signed [W-1:0] dx_w;
      logic signed [W-1:0] dy_w;
      logic                cw_w;
      logic [PB-1:0]       ang_w;

      assign dx_w  = cy_ff[j] >>> j;
      assign dy_w  = cx_ff[j] >>> j;
      assign cw_w  = !cy_ff[j][W-1] && (cy_ff[j] != '0);
      assign ang_w = vaf_pkg::atan_entry(vaf_pkg::TAB_IDX_BITS'(j));

      always_comb begin
         if (cw_w) begin
            cx_in[j+1] = cx_ff[j] + dx_w;
            cy_in[j+1] = cy_ff[j] - dy_w;
            cz_in[j+1] = cz_ff[j] + ang_w;
         end else begin
            cx_in[j+1] = cx_ff[j] - dx_w;
            cy_in[j+1] = cy_ff[j] + dy_w;
            cz_in[j+1] = cz_ff[j] - ang_w;
         end
      end
   end

   // Output register.
   logic [PB-1:0]                    zr_w;
   logic [vaf_pkg::ANGLE_BITS-1:0]   angle_ff;
   logic                             zero_ff;

   assign zr_w = cz_ff[ITERATIONS] + vaf_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (ready_w[0]) begin
         xa_ff <= req_ch.x_coord;
         ya_ff <= req_ch.y_coord;
      end
      if (ready_w[1]) begin
         sqx_ff  <= SQ_W'(sqx_w);
         sqy_ff  <= SQ_W'(sqy_w);
         xb_ff   <= xb_in;
         yb_ff   <= yb_in;
         half_ff <= xa_ff[COORD_BITS-1];
      end
      if (ready_w[2]) begin
         cx_ff[0]    <= xb_ff;
         cy_ff[0]    <= yb_ff;
         cz_ff[0]    <= {half_ff, {(PB-1){1'b0}}};
         short_ff[0] <= short_in;
      end
      for (int j = 1; j <= ITERATIONS; j++) begin
         if (ready_w[j+2]) begin
            cx_ff[j]    <= cx_in[j];
            cy_ff[j]    <= cy_in[j];
            cz_ff[j]    <= cz_in[j];
            short_ff[j] <= short_ff[j-1];
         end
      end
      if (ready_w[OUT_IDX]) begin
         angle_ff <= short_ff[ITERATIONS] ? '0 : zr_w[PB-1 -: vaf_pkg::ANGLE_BITS];
         zero_ff  <= short_ff[ITERATIONS];
      end
   end

   assign rsp_ch.valid       = valid_ff[OUT_IDX];
   assign rsp_ch.angle       = angle_ff;
   assign rsp_ch.zero_vector = zero_ff;

   // The input side only stalls when the first stage and the output both hold items.
   assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (valid_ff[0] && rsp_ch.valid))
      else $error("input stalled while the pipeline had room");

   assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> valid_ff[0])
      else $error("accepted item did not enter the input register");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && (radius_sq_ff == '0)) |-> !short_ff[0])
      else $error("vector flagged short with a zero minimum radius");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.zero_vector) |-> (rsp_ch.angle == '0))
      else $error("short vector produced a nonzero angle");

endmodule
